/* rtl/saon_pkg.sv */
package saon_pkg;

  localparam int DIST_W  = 13;
  localparam int SPEED_W = 10;
  localparam int STEER_W = 11;
  localparam int TICKS_W = 8;
  localparam int LIN_W   = 11;
  localparam int ANG_W   = 12;
  localparam int ANGLE_W = 11;
  localparam int PHASE_W = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEER     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REV_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRN_TICKS = 3'd4;

  localparam logic [DIST_W-1:0]         RST_THRESHOLD = 13'd300;
  localparam logic [SPEED_W-1:0]        RST_SPEED     = 10'd200;
  localparam logic signed [STEER_W-1:0] RST_STEER     = 11'sd300;
  localparam logic [TICKS_W-1:0]        RST_REV_TICKS = 8'd10;
  localparam logic [TICKS_W-1:0]        RST_TRN_TICKS = 8'd15;

  localparam logic [ANGLE_W-1:0] TILT_LO  = 11'd600;
  localparam logic [ANGLE_W-1:0] TILT_HI  = 11'd1100;
  localparam logic [ANGLE_W-1:0] TILT_INC = 11'd3;
  localparam logic [ANGLE_W-1:0] PAN_LO   = 11'd450;
  localparam logic [ANGLE_W-1:0] PAN_HI   = 11'd1350;
  localparam logic [ANGLE_W-1:0] PAN_INC  = 11'd15;
  localparam logic [ANGLE_W-1:0] SWEEP_HOME = 11'd900;

  localparam logic [PHASE_W-1:0] PH_CODE_IDLE    = 2'd0;
  localparam logic [PHASE_W-1:0] PH_CODE_REVERSE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_CODE_TURN    = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_REVERSE = 3'b010,
    PH_TURN    = 3'b100
  } phase_t;

  typedef struct packed {
    logic [DIST_W-1:0]         threshold;
    logic [SPEED_W-1:0]        speed;
    logic signed [STEER_W-1:0] steer;
    logic [TICKS_W-1:0]        rev_ticks;
    logic [TICKS_W-1:0]        trn_ticks;
  } cfg_t;

endpackage

/* rtl/saon_sweep.sv */
module saon_sweep
  import saon_pkg::*;
#(
  parameter logic [ANGLE_W-1:0] STEP     = TILT_INC,
  parameter logic [ANGLE_W-1:0] LO       = TILT_LO,
  parameter logic [ANGLE_W-1:0] HI       = TILT_HI,
  parameter logic               RESET_UP = 1'b0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  output logic [ANGLE_W-1:0] pos_nxt
);

  logic [ANGLE_W-1:0] pos_r;
  logic               up_r;
  logic               up_nxt;

  always_comb begin
    pos_nxt = up_r ? (pos_r + STEP) : (pos_r - STEP);
    up_nxt  = up_r;
    if (pos_nxt >= HI) up_nxt = 1'b0;
    if (pos_nxt <= LO) up_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= SWEEP_HOME;
      up_r  <= RESET_UP;
    end else if (advance) begin
      pos_r <= pos_nxt;
      up_r  <= up_nxt;
    end
  end

  // a sweep may overshoot a bound by less than one step
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r + STEP > LO) && (pos_r < HI + STEP))
    else $error("sweep position left its bounds");

endmodule

/* rtl/saon_nav.sv */
module saon_nav
  import saon_pkg::*;
#(
  parameter int COUNTER_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     advance,
  input  logic                     clear,
  input  logic [DIST_W-1:0]        range_mm,
  input  cfg_t                     cfg,
  output logic signed [LIN_W-1:0]  lin,
  output logic signed [ANG_W-1:0]  ang,
  output logic [PHASE_W-1:0]       phase_code
);

  localparam int LW = (COUNTER_BITS > TICKS_W) ? COUNTER_BITS : TICKS_W;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

  phase_t                  phase_r, phase_nxt, phase_cur;
  logic [COUNTER_BITS-1:0] cnt_r, cnt_nxt, cnt_cur, cnt_dec;
  logic [COUNTER_BITS-1:0] rev_load, trn_load;
  logic signed [LIN_W-1:0] spd_pos, spd_neg;
  logic signed [ANG_W-1:0] steer_pos, steer_neg, steer_dbl;
  logic signed [12:0]      steer13, dbl13;

  // saturate 8-bit tick counts to the counter width
  function automatic logic [COUNTER_BITS-1:0] sat_load(input logic [TICKS_W-1:0] v);
    logic [LW-1:0] ext;
    ext = LW'(v);
    return (ext > LW'(CNT_MAX)) ? CNT_MAX : COUNTER_BITS'(ext);
  endfunction

  always_comb begin
    rev_load  = sat_load(cfg.rev_ticks);
    trn_load  = sat_load(cfg.trn_ticks);
    spd_pos   = signed'(LIN_W'(cfg.speed));
    spd_neg   = -spd_pos;
    steer_pos = ANG_W'(cfg.steer);
    steer_neg = -steer_pos;
    steer13   = 13'(cfg.steer);
    dbl13     = -(steer13 <<< 1);
    steer_dbl = (dbl13 > 13'sd2047) ? 12'sd2047 : dbl13[ANG_W-1:0];
  end

  always_comb begin
    phase_cur = clear ? PH_IDLE : phase_r;
    cnt_cur   = clear ? '0 : cnt_r;
    cnt_dec   = (cnt_cur != '0) ? (cnt_cur - 1'b1) : '0;
    phase_nxt = phase_cur;
    cnt_nxt   = cnt_cur;
    lin       = spd_pos;
    ang       = steer_pos;
    case (phase_cur)
      PH_REVERSE: begin
        lin     = spd_neg;
        ang     = steer_neg;
        cnt_nxt = cnt_dec;
        if (cnt_dec == '0) begin
          phase_nxt = PH_TURN;
          cnt_nxt   = trn_load;
        end
      end
      PH_TURN: begin
        lin     = spd_pos;
        ang     = steer_dbl;
        cnt_nxt = cnt_dec;
        if (cnt_dec == '0) phase_nxt = PH_IDLE;
      end
      default: begin
        if (range_mm < cfg.threshold) begin
          phase_nxt = PH_REVERSE;
          cnt_nxt   = rev_load;
          lin       = spd_neg;
          ang       = steer_neg;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
    endcase
    case (phase_nxt)
      PH_REVERSE: phase_code = PH_CODE_REVERSE;
      PH_TURN:    phase_code = PH_CODE_TURN;
      default:    phase_code = PH_CODE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (cnt_r == '0))
    else $error("counter nonzero while idle");

  a_turn_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !clear && (phase_r == PH_TURN) && (cnt_r <= 1)) |=> (phase_r == PH_IDLE))
    else $error("turn phase did not end when counter ran out");

endmodule

/* rtl/scan_and_obstacle_avoid_nav_top.sv */
// scan and obstacle avoid navigation tick engine
//
// input channel (in_valid/in_ready): one request per control tick, carrying a
// distance reading and a clear flag that aborts any avoidance maneuver.
// result channel (out_valid/out_ready): one result per request with drive
// speed, steer, tilt and pan servo angles and the avoidance phase after the
// tick. configuration (cfg_we/cfg_index/cfg_wdata) is to be written only while
// idle, by the user; the block itself does not enforce this.
// a request is captured in an input register, is evaluated by the phase
// controller and the two sweep generators, and lands in the output register;
// throughput is one request per cycle while the receiver does not stall. the
// state of the controller and sweeps advances only when a request moves into
// the output register.
// a stalled receiver holds the output register; the input register still
// takes one more request, after which in_ready drops until out_ready returns.
// synchronous reset restores the default configuration, idle phase, both
// servos at 90.0 degrees, tilt heading down and pan heading up.
module scan_and_obstacle_avoid_nav_top
  import saon_pkg::*;
#(
  parameter int COUNTER_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [DIST_W-1:0]          in_distance_mm,
  input  logic                       in_clear_avoid,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [LIN_W-1:0]    out_linear_velocity,
  output logic signed [ANG_W-1:0]    out_angular_velocity,
  output logic [ANGLE_W-1:0]         out_tilt_angle,
  output logic [ANGLE_W-1:0]         out_pan_angle,
  output logic [PHASE_W-1:0]         out_avoid_phase,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

  cfg_t                    cfg_r;
  logic                    s0_valid_r;
  logic [DIST_W-1:0]       s0_dist_r;
  logic                    s0_clear_r;
  logic                    out_valid_r;
  logic signed [LIN_W-1:0] lin_r;
  logic signed [ANG_W-1:0] ang_r;
  logic [ANGLE_W-1:0]      tilt_r, pan_r;
  logic [PHASE_W-1:0]      phase_code_r;
  logic                    advance;
  logic signed [LIN_W-1:0] lin_nxt;
  logic signed [ANG_W-1:0] ang_nxt;
  logic [ANGLE_W-1:0]      tilt_nxt, pan_nxt;
  logic [PHASE_W-1:0]      phase_code_nxt;

  assign advance  = s0_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s0_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= RST_THRESHOLD;
      cfg_r.speed     <= RST_SPEED;
      cfg_r.steer     <= RST_STEER;
      cfg_r.rev_ticks <= RST_REV_TICKS;
      cfg_r.trn_ticks <= RST_TRN_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: cfg_r.threshold <= cfg_wdata;
        REG_SPEED:     cfg_r.speed     <= cfg_wdata[SPEED_W-1:0];
        REG_STEER:     cfg_r.steer     <= signed'(cfg_wdata[STEER_W-1:0]);
        REG_REV_TICKS: cfg_r.rev_ticks <= cfg_wdata[TICKS_W-1:0];
        REG_TRN_TICKS: cfg_r.trn_ticks <= cfg_wdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0_dist_r  <= in_distance_mm;
      s0_clear_r <= in_clear_avoid;
    end
  end

  saon_nav #(.COUNTER_BITS(COUNTER_BITS)) u_nav (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .clear      (s0_clear_r),
    .range_mm   (s0_dist_r),
    .cfg        (cfg_r),
    .lin        (lin_nxt),
    .ang        (ang_nxt),
    .phase_code (phase_code_nxt)
  );

  saon_sweep #(.STEP(TILT_INC), .LO(TILT_LO), .HI(TILT_HI), .RESET_UP(1'b0)) u_tilt (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .pos_nxt (tilt_nxt)
  );

  saon_sweep #(.STEP(PAN_INC), .LO(PAN_LO), .HI(PAN_HI), .RESET_UP(1'b1)) u_pan (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .pos_nxt (pan_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lin_r        <= lin_nxt;
      ang_r        <= ang_nxt;
      tilt_r       <= tilt_nxt;
      pan_r        <= pan_nxt;
      phase_code_r <= phase_code_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_linear_velocity  = lin_r;
  assign out_angular_velocity = ang_r;
  assign out_tilt_angle       = tilt_r;
  assign out_pan_angle        = pan_r;
  assign out_avoid_phase      = phase_code_r;

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && !advance) |=> s0_valid_r)
    else $error("pending request lost from input register");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s0_valid_r && out_valid_r && !out_ready))
    else $error("input stalled while pipeline had room");

endmodule

/* tb/tb_scan_and_obstacle_avoid_nav_top.sv */
`timescale 1ns / 1ps

module tb_scan_and_obstacle_avoid_nav_top;
  import saon_pkg::*;

  localparam int CNT_BITS     = 8;
  localparam int CNT_TOP      = (1 << CNT_BITS) - 1;
  localparam int ANG_TOP      = (1 << (ANG_W - 1)) - 1;
  localparam int DIST_MAX     = (1 << DIST_W) - 1;
  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    logic signed [LIN_W-1:0] linear;
    logic signed [ANG_W-1:0] angular;
    logic [ANGLE_W-1:0]      tilt;
    logic [ANGLE_W-1:0]      pan;
    logic [PHASE_W-1:0]      phase;
  } nav_cmd_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [DIST_W-1:0]         in_distance_mm;
  logic                      in_clear_avoid;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [LIN_W-1:0]   out_linear_velocity;
  logic signed [ANG_W-1:0]   out_angular_velocity;
  logic [ANGLE_W-1:0]        out_tilt_angle;
  logic [ANGLE_W-1:0]        out_pan_angle;
  logic [PHASE_W-1:0]        out_avoid_phase;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_wdata;

  // shadow copy of the navigation state and its registers
  logic [DIST_W-1:0]         thr_reg;
  logic [SPEED_W-1:0]        speed_reg;
  logic signed [STEER_W-1:0] steer_reg;
  logic [TICKS_W-1:0]        rev_reg;
  logic [TICKS_W-1:0]        trn_reg;
  logic [PHASE_W-1:0]        nav_phase;
  int                        nav_count;
  int                        tilt_pos;
  int                        pan_pos;
  bit                        tilt_up;
  bit                        pan_up;

  nav_cmd_t                  pending_cmds[$];
  int                        fail_count;
  bit                        tx_gaps_en;
  bit                        rx_stall_en;

  scan_and_obstacle_avoid_nav_top #(
    .COUNTER_BITS(CNT_BITS)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_distance_mm      (in_distance_mm),
    .in_clear_avoid      (in_clear_avoid),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_linear_velocity (out_linear_velocity),
    .out_angular_velocity(out_angular_velocity),
    .out_tilt_angle      (out_tilt_angle),
    .out_pan_angle       (out_pan_angle),
    .out_avoid_phase     (out_avoid_phase),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_nav_model();
    thr_reg   = RST_THRESHOLD;
    speed_reg = RST_SPEED;
    steer_reg = RST_STEER;
    rev_reg   = RST_REV_TICKS;
    trn_reg   = RST_TRN_TICKS;
    nav_phase = PH_CODE_IDLE;
    nav_count = 0;
    tilt_pos  = SWEEP_HOME;
    tilt_up   = 1'b0;
    pan_pos   = SWEEP_HOME;
    pan_up    = 1'b1;
  endfunction

  function automatic int clamp_count(int v);
    return (v > CNT_TOP) ? CNT_TOP : v;
  endfunction

  function automatic void advance_sweep(inout int pos, inout bit up, input int step,
                                        input int lo, input int hi);
    pos += up ? step : -step;
    if (pos >= hi) up = 1'b0;
    if (pos <= lo) up = 1'b1;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_THRESHOLD: thr_reg   = data[DIST_W-1:0];
      REG_SPEED:     speed_reg = data[SPEED_W-1:0];
      REG_STEER:     steer_reg = data[STEER_W-1:0];
      REG_REV_TICKS: rev_reg   = data[TICKS_W-1:0];
      REG_TRN_TICKS: trn_reg   = data[TICKS_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic nav_cmd_t predict_nav_tick(logic [DIST_W-1:0] range_mm, logic clr);
    nav_cmd_t r;
    int lin;
    int ang;
    int spd;
    int str;
    spd = int'(speed_reg);
    str = int'(steer_reg);
    if (clr) begin
      nav_phase = PH_CODE_IDLE;
      nav_count = 0;
    end
    advance_sweep(tilt_pos, tilt_up, TILT_INC, TILT_LO, TILT_HI);
    advance_sweep(pan_pos, pan_up, PAN_INC, PAN_LO, PAN_HI);
    if (nav_phase == PH_CODE_REVERSE || nav_phase == PH_CODE_TURN) begin
      if (nav_count > 0) nav_count--;
      if (nav_phase == PH_CODE_REVERSE) begin
        lin = -spd;
        ang = -str;
        if (nav_count == 0) begin
          nav_phase = PH_CODE_TURN;
          nav_count = clamp_count(int'(trn_reg));
        end
      end else begin
        lin = spd;
        ang = -2 * str;
        if (ang > ANG_TOP) ang = ANG_TOP;
        if (nav_count == 0) nav_phase = PH_CODE_IDLE;
      end
    end else if (range_mm < thr_reg) begin
      nav_phase = PH_CODE_REVERSE;
      nav_count = clamp_count(int'(rev_reg));
      lin = -spd;
      ang = -str;
    end else begin
      nav_phase = PH_CODE_IDLE;
      lin = spd;
      ang = str;
    end
    r.linear  = lin[LIN_W-1:0];
    r.angular = ang[ANG_W-1:0];
    r.tilt    = tilt_pos[ANGLE_W-1:0];
    r.pan     = pan_pos[ANGLE_W-1:0];
    r.phase   = nav_phase;
    return r;
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  // valid stays up across back-to-back requests; it drops only ahead of a gap or a drain
  task automatic send_tick(input logic [DIST_W-1:0] range_mm, input logic clr);
    nav_cmd_t cmd;
    if (tx_gaps_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_distance_mm <= range_mm;
    in_clear_avoid <= clr;
    do @(posedge clk); while (!in_ready);
    cmd = predict_nav_tick(range_mm, clr);
    pending_cmds.push_back(cmd);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    apply_reg(idx, data);
  endtask

  task automatic write_all_regs(input logic [DIST_W-1:0] thr, input logic [SPEED_W-1:0] spd,
                                input logic signed [STEER_W-1:0] str,
                                input logic [TICKS_W-1:0] rev, input logic [TICKS_W-1:0] trn,
                                input bit junk_high);
    logic [CFG_DATA_W-1:0] w;
    w = junk_high ? CFG_DATA_W'($urandom) : '0;
    w[DIST_W-1:0] = thr;
    write_reg(REG_THRESHOLD, w);
    w = junk_high ? CFG_DATA_W'($urandom) : '0;
    w[SPEED_W-1:0] = spd;
    write_reg(REG_SPEED, w);
    w = junk_high ? CFG_DATA_W'($urandom) : '0;
    w[STEER_W-1:0] = str;
    write_reg(REG_STEER, w);
    w = junk_high ? CFG_DATA_W'($urandom) : '0;
    w[TICKS_W-1:0] = rev;
    write_reg(REG_REV_TICKS, w);
    w = junk_high ? CFG_DATA_W'($urandom) : '0;
    w[TICKS_W-1:0] = trn;
    write_reg(REG_TRN_TICKS, w);
    // unmapped indexes must be ignored
    if (junk_high && $urandom_range(0, 2) == 0) begin
      for (int idx = int'(REG_TRN_TICKS) + 1; idx < (1 << CFG_IDX_W); idx++) begin
        write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
      end
    end
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // reset configuration: cruise, threshold edge, trigger, ignored reading, clear
  task automatic test_default_config();
    tx_gaps_en  = 1'b0;
    rx_stall_en = 1'b0;
    send_tick(DIST_W'(DIST_MAX), 1'b0);
    send_tick(RST_THRESHOLD, 1'b0);
    send_tick(RST_THRESHOLD - 1'b1, 1'b0);
    send_tick('0, 1'b0);
    send_tick(DIST_W'(DIST_MAX), 1'b1);
    send_tick('0, 1'b1);
    send_tick(DIST_W'(DIST_MAX), 1'b1);
    wait_drain();
  endtask

  // zero counter loads end each phase on the next tick; doubled steer saturates
  task automatic test_zero_counts();
    tx_gaps_en  = 1'b1;
    rx_stall_en = 1'b1;
    write_all_regs(DIST_W'(DIST_MAX), '1, -11'sd1024, '0, '0, 1'b0);
    send_tick(DIST_W'(DIST_MAX - 1), 1'b0);
    send_tick(DIST_W'(DIST_MAX), 1'b0);
    send_tick(DIST_W'(DIST_MAX), 1'b0);
    send_tick(DIST_W'(DIST_MAX), 1'b0);
    send_tick('0, 1'b0);
    send_tick('0, 1'b1);
    wait_drain();
  endtask

  // zero threshold never triggers; largest positive steer, zero speed
  task automatic test_zero_threshold();
    tx_gaps_en  = 1'b0;
    rx_stall_en = 1'b1;
    write_all_regs('0, '0, 11'sd1023, 8'd1, 8'd2, 1'b0);
    send_tick('0, 1'b0);
    send_tick('0, 1'b1);
    wait_drain();
  endtask

  task automatic run_random_phase(input int n_ticks, input bit long_counts);
    logic [DIST_W-1:0]         thr;
    logic [SPEED_W-1:0]        spd;
    logic signed [STEER_W-1:0] str;
    logic [TICKS_W-1:0]        rev;
    logic [TICKS_W-1:0]        trn;
    logic [DIST_W-1:0]         range_mm;
    logic                      clr;
    int                        clear_pct;
    wait_drain();
    case ($urandom_range(0, 4))
      0:       thr = '0;
      1:       thr = DIST_W'(DIST_MAX);
      2:       thr = DIST_W'($urandom);
      default: thr = DIST_W'($urandom_range(100, 1500));
    endcase
    case ($urandom_range(0, 4))
      0:       spd = '0;
      1:       spd = '1;
      2:       spd = SPEED_W'(1000);
      default: spd = SPEED_W'($urandom);
    endcase
    case ($urandom_range(0, 6))
      0:       str = -11'sd1024;
      1:       str = 11'sd1023;
      2:       str = -11'sd1000;
      3:       str = 11'sd1000;
      4:       str = STEER_W'($urandom_range(0, 600)) - 11'sd300;
      default: str = STEER_W'($urandom);
    endcase
    rev = ($urandom_range(0, 5) == 0) ? '0 : TICKS_W'($urandom_range(1, 12));
    trn = ($urandom_range(0, 5) == 0) ? '0 : TICKS_W'($urandom_range(1, 12));
    if ($urandom_range(0, 7) == 0) rev = '1;
    if ($urandom_range(0, 7) == 0) trn = '1;
    clear_pct = $urandom_range(0, 6);
    if (long_counts) begin
      thr = DIST_W'($urandom_range(1, DIST_MAX));
      rev = '1;
      trn = '1;
      clear_pct = 0;
    end
    write_all_regs(thr, spd, str, rev, trn, 1'b1);
    tx_gaps_en  = ($urandom_range(0, 2) != 0);
    rx_stall_en = ($urandom_range(0, 2) != 0);
    repeat (n_ticks) begin
      clr = ($urandom_range(0, 99) < clear_pct);
      case ($urandom_range(0, 9))
        0:       range_mm = DIST_W'($urandom);
        1:       range_mm = $urandom_range(0, 1) ? DIST_W'(0) : DIST_W'(DIST_MAX);
        2, 3, 4: range_mm = (thr_reg == 0) ? DIST_W'(0) :
                            DIST_W'($urandom_range(0, thr_reg - 1));
        default: range_mm = DIST_W'($urandom_range(thr_reg, DIST_MAX));
      endcase
      send_tick(range_mm, clr);
    end
  endtask

  task automatic test_random_config(input int n_phases, input int ticks_per_phase);
    repeat (n_phases) run_random_phase(ticks_per_phase, 1'b0);
  endtask

  // full-range counters: 255 ticks reversing, then 255 turning
  task automatic test_long_counts(input int n_ticks);
    run_random_phase(n_ticks, 1'b1);
  endtask

  initial begin : ready_drive
    int stall;
    stall = 0;
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
        stall = pick_gap() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_cmds
    nav_cmd_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        $error("unexpected result: no request pending");
        fail_count++;
      end else begin
        want = pending_cmds.pop_front();
        if (out_linear_velocity !== want.linear) begin
          $error("linear_velocity: expected %0d, got %0d", want.linear, out_linear_velocity);
          fail_count++;
        end
        if (out_angular_velocity !== want.angular) begin
          $error("angular_velocity: expected %0d, got %0d", want.angular,
                 out_angular_velocity);
          fail_count++;
        end
        if (out_tilt_angle !== want.tilt) begin
          $error("tilt_angle: expected %0d, got %0d", want.tilt, out_tilt_angle);
          fail_count++;
        end
        if (out_pan_angle !== want.pan) begin
          $error("pan_angle: expected %0d, got %0d", want.pan, out_pan_angle);
          fail_count++;
        end
        if (out_avoid_phase !== want.phase) begin
          $error("avoid_phase: expected %0d, got %0d", want.phase, out_avoid_phase);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("scan_and_obstacle_avoid_nav_top test failed");
    $finish;
  end

  initial begin : main_seq
    fail_count     = 0;
    tx_gaps_en     = 1'b0;
    rx_stall_en    = 1'b0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_distance_mm <= '0;
    in_clear_avoid <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    reset_nav_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_config();
    test_zero_counts();
    test_zero_threshold();
    test_random_config(8, 100);
    test_long_counts(530);
    wait_drain();
    if (fail_count == 0 && pending_cmds.size() == 0) begin
      $display("scan_and_obstacle_avoid_nav_top test passed");
    end else begin
      $display("scan_and_obstacle_avoid_nav_top test failed");
    end
    $finish;
  end

endmodule
